>>> src/ufwp_pkg.sv
// ----------------------------------------------------------------------------
// ufwp_pkg
// Shared types and helpers for the serial frame word packer.
// ----------------------------------------------------------------------------
package ufwp_pkg;

  localparam int unsigned WORDS_MAX = 3;

  // one line word as it leaves the block
  typedef struct packed {
    logic [7:0] shift_word;
    logic [3:0] bit_count;
    logic       message_done;
  } word_t;

  // every word that one input byte causes
  typedef struct packed {
    word_t [WORDS_MAX-1:0] words;
    logic  [1:0]           num;     // 1..3 words valid
  } plan_t;

  localparam logic [7:0] MASK_1_LO = 8'h55;
  localparam logic [7:0] MASK_1_HI = 8'haa;
  localparam logic [7:0] MASK_2_LO = 8'h33;
  localparam logic [7:0] MASK_2_HI = 8'hcc;
  localparam logic [7:0] MASK_4_LO = 8'h0f;
  localparam logic [7:0] MASK_4_HI = 8'hf0;

  localparam logic [3:0] FULL_WORD = 4'd8;

  function automatic logic [7:0] bit_mirror(input logic [7:0] v);
    logic [7:0] x;
    x = ((v >> 1) & MASK_1_LO) | ((v << 1) & MASK_1_HI);
    x = ((x >> 2) & MASK_2_LO) | ((x << 2) & MASK_2_HI);
    x = ((x >> 4) & MASK_4_LO) | ((x << 4) & MASK_4_HI);
    return x;
  endfunction

endpackage

>>> src/ufwp_if.sv
// ----------------------------------------------------------------------------
// ufwp_in_if / ufwp_out_if
// Valid/ready channels for message bytes and line words.
// ----------------------------------------------------------------------------
interface ufwp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ufwp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_word;
  logic [3:0] bit_count;
  logic       message_done;
  logic       run_last;

  modport source (output valid, output shift_word, output bit_count,
                  output message_done, output run_last, input ready);
  modport sink   (input valid, input shift_word, input bit_count,
                  input message_done, input run_last, output ready);
endinterface

>>> src/uart_frame_word_packer.sv
// ----------------------------------------------------------------------------
// A byte's word list is written into the queue, then its first word is loaded
// into the output register. Each byte causes 1 to 3 line words, which the
// word sequencer emits in turn from the head of the queue.
// The front accepts a new byte each cycle while the queue has room.
// Reset: synchronous active-low rst_n clears held bits, queue and output valid.
// ----------------------------------------------------------------------------
// uart_frame_word_packer
// Packs start/data/stop serial frames into MSB-first 8-bit line words.
// ----------------------------------------------------------------------------
module uart_frame_word_packer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  ufwp_in_if.sink    in_chan,
  ufwp_out_if.source out_chan
);
  import ufwp_pkg::*;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  plan_t push_plan;
  plan_t head_plan;

  ufwp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_data_byte (in_chan.data_byte),
    .in_last_byte (in_chan.last_byte),
    .push         (push),
    .push_plan    (push_plan),
    .q_full       (q_full)
  );

  ufwp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (push_plan),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head_plan (head_plan)
  );

  ufwp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (q_empty),
    .head_plan        (head_plan),
    .pop              (pop),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_shift_word   (out_chan.shift_word),
    .out_bit_count    (out_chan.bit_count),
    .out_message_done (out_chan.message_done),
    .out_run_last     (out_chan.run_last)
  );

endmodule

>>> src/ufwp_front.sv
// ----------------------------------------------------------------------------
// ufwp_front
// Takes bytes, frames them against the held-over bits and builds the
// list of line words for each byte.
// ----------------------------------------------------------------------------
module ufwp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                push,
  output ufwp_pkg::plan_t     push_plan,
  input  logic                q_full
);
  import ufwp_pkg::*;

  logic [6:0] held_r, held_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] r;
  logic [2:0] n_a;
  logic [6:0] held_a;
  logic [7:0] wf;
  plan_t      plan;

  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;
  assign push_plan = plan;

  always_comb begin
    r      = bit_mirror(in_data_byte);
    plan   = '0;
    n_a    = 3'd1;
    held_a = {6'd0, r[0]};
    wf     = '0;

    if (cnt_r == 3'd0) begin
      plan.words[0] = '{shift_word: r >> 1, bit_count: FULL_WORD, message_done: 1'b0};
      plan.num      = 2'd1;
    end else if (cnt_r >= 3'd6) begin
      // held bits plus stop bit fill a word, then a fresh aligned frame
      plan.words[0] = '{shift_word: {held_r, 1'b1}, bit_count: FULL_WORD,
                        message_done: 1'b0};
      plan.words[1] = '{shift_word: r >> 1, bit_count: FULL_WORD, message_done: 1'b0};
      plan.num      = 2'd2;
    end else begin
      plan.words[0].shift_word = (8'({1'b0, held_r}) << (4'd8 - {1'b0, cnt_r}))
                               | (8'd1 << (3'd7 - cnt_r))
                               | (r >> ({1'b0, cnt_r} + 4'd2));
      plan.words[0].bit_count  = FULL_WORD;
      plan.num                 = 2'd1;
      n_a    = cnt_r + 3'd2;
      held_a = 7'(r & ~(8'hff << n_a));
    end

    if (in_last_byte) begin
      // idle-high bit below the stop bit, dropped when no room remains
      wf = (8'({1'b0, held_a}) << (4'd8 - {1'b0, n_a})) | (8'd1 << (3'd7 - n_a));
      if (n_a != 3'd7) wf = wf | (8'd1 << (3'd6 - n_a));
      if (plan.num == 2'd2) begin
        plan.words[2] = '{shift_word: wf, bit_count: {1'b0, n_a} + 4'd1,
                          message_done: 1'b1};
      end else begin
        plan.words[1] = '{shift_word: wf, bit_count: {1'b0, n_a} + 4'd1,
                          message_done: 1'b1};
      end
      plan.num = plan.num + 2'd1;
    end
  end

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      held_nxt = in_last_byte ? 7'd0 : held_a;
      cnt_nxt  = in_last_byte ? 3'd0 : n_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> src/ufwp_queue.sv
// ----------------------------------------------------------------------------
// ufwp_queue
// Short FIFO of word lists between the framing front and the word sequencer.
// ----------------------------------------------------------------------------
module ufwp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ufwp_pkg::plan_t push_plan,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ufwp_pkg::plan_t head_plan
);
  import ufwp_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  plan_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_plan = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> src/ufwp_back.sv
// ----------------------------------------------------------------------------
// ufwp_back
// Steps through the head word list, one word per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module ufwp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  ufwp_pkg::plan_t head_plan,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_shift_word,
  output logic [3:0]      out_bit_count,
  output logic            out_message_done,
  output logic            out_run_last
);
  import ufwp_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  word_t      word_r, word_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       final_word;

  assign load       = (!vld_r || out_ready) && !empty;
  assign final_word = (idx_r == head_plan.num - 2'd1);
  assign pop        = load && final_word;

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_ready;
    word_nxt = word_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      word_nxt = head_plan.words[idx_r];
      last_nxt = final_word;
      idx_nxt  = final_word ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = vld_r;
  assign out_shift_word   = word_r.shift_word;
  assign out_bit_count    = word_r.bit_count;
  assign out_message_done = word_r.message_done;
  assign out_run_last     = last_r;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uart_frame_word_packer. A table of directed bytes
// walks every held-over count and every flush length. Random messages follow,
// with random gaps on the request side and random stalls on the word side.
// Each accepted line word is checked against an in-bench frame packer.
// ----------------------------------------------------------------------------
module tb;
  import ufwp_pkg::*;

  typedef struct packed {
    logic [7:0] shift_word;
    logic [3:0] bit_count;
    logic       message_done;
    logic       run_last;
  } line_word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         typed;      // number of words typed in, 0 = use the packer
    line_word_t t0;
    line_word_t t1;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ufwp_in_if  in_chan ();
  ufwp_out_if out_chan ();

  uart_frame_word_packer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  // in-bench packer state
  logic [6:0]  held_bits = '0;
  logic [2:0]  held_cnt  = '0;
  line_word_t  pending_words[$];
  byte_row_t   byte_rows[$];

  int errors      = 0;
  int words_seen  = 0;
  int flushes     = 0;
  int messages    = 0;
  int sink_stall  = 0;
  bit calm        = 1'b0;

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.data_byte = 8'h00;
    in_chan.last_byte = 1'b0;
    out_chan.ready    = 1'b0;
  end

  function automatic line_word_t make_word(logic [7:0] w, logic [3:0] c, logic d);
    line_word_t lw;
    lw.shift_word   = w;
    lw.bit_count    = c;
    lw.message_done = d;
    lw.run_last     = 1'b0;
    return lw;
  endfunction

  // frame one byte into line words and queue them
  function automatic void pack_frame(input logic [7:0] data, input logic last);
    line_word_t  w[3];
    logic [7:0]  lsb_first;
    logic [31:0] n;
    logic [31:0] hb;
    logic [31:0] acc;
    int          k;
    for (int i = 0; i < 8; i++) lsb_first[7-i] = data[i];
    n  = {29'd0, held_cnt};
    hb = {25'd0, held_bits};
    k  = 0;
    if (n == 0) begin
      w[k] = make_word(lsb_first >> 1, FULL_WORD, 1'b0);
      k++;
      hb = {31'd0, lsb_first[0]};
      n  = 1;
    end else if (n >= 6) begin
      // held bits plus stop fill a word, then a fresh aligned frame
      acc  = (hb << 1) | 32'd1;
      w[k] = make_word(acc[7:0], FULL_WORD, 1'b0);
      k++;
      w[k] = make_word(lsb_first >> 1, FULL_WORD, 1'b0);
      k++;
      hb = {31'd0, lsb_first[0]};
      n  = 1;
    end else begin
      acc  = (hb << (8 - n)) | (32'd1 << (7 - n)) | ({24'd0, lsb_first} >> (n + 2));
      w[k] = make_word(acc[7:0], FULL_WORD, 1'b0);
      k++;
      n  = n + 2;
      hb = {24'd0, lsb_first} & ((32'd1 << n) - 1);
    end
    if (last) begin
      acc = (hb << (8 - n)) | (32'd1 << (7 - n));
      if (n < 7) acc = acc | (32'd1 << (6 - n));   // idle bit only if it fits
      w[k] = make_word(acc[7:0], n[3:0] + 4'd1, 1'b1);
      k++;
      hb = 0;
      n  = 0;
    end
    w[k-1].run_last = 1'b1;
    for (int i = 0; i < k; i++) pending_words.push_back(w[i]);
    held_bits = hb[6:0];
    held_cnt  = n[2:0];
  endfunction

  function automatic void add_row(logic [7:0] d, logic l, int typed,
                                  line_word_t t0, line_word_t t1);
    byte_row_t row;
    row.data  = d;
    row.last  = l;
    row.typed = typed;
    row.t0    = t0;
    row.t1    = t1;
    byte_rows.push_back(row);
  endfunction

  function automatic int source_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_byte(input logic [7:0] d, input logic l, input int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= d;
    in_chan.last_byte <= l;
    do @(posedge clk); while (!in_chan.ready);
    if (l) messages++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // word side: ready with random stalls, mostly short
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_chan.ready <= 1'b0;
    end else if (calm || r >= 20) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= 1'b0;
      sink_stall <= (r < 16) ? $urandom_range(0, 2) : $urandom_range(8, 40);
    end
  end

  // word checker
  always @(posedge clk) begin
    line_word_t exp_w;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected line word %h count %0d", out_chan.shift_word,
               out_chan.bit_count);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (exp_w.message_done) flushes++;
        if (out_chan.shift_word !== exp_w.shift_word) begin
          $error("shift_word: expected %h, got %h", exp_w.shift_word, out_chan.shift_word);
          errors++;
        end
        if (out_chan.bit_count !== exp_w.bit_count) begin
          $error("bit_count: expected %0d, got %0d", exp_w.bit_count, out_chan.bit_count);
          errors++;
        end
        if (out_chan.message_done !== exp_w.message_done) begin
          $error("message_done: expected %b, got %b", exp_w.message_done,
                 out_chan.message_done);
          errors++;
        end
        if (out_chan.run_last !== exp_w.run_last) begin
          $error("run_last: expected %b, got %b", exp_w.run_last, out_chan.run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int          base_len;
    int          rand_items;
    int          msg_len;
    int          r;
    bit          drained_once;
    logic [7:0]  d;
    logic        l;
    line_word_t  none;
    none         = '0;
    rand_items   = 0;
    drained_once = 1'b0;

    // from reset: aligned frames, flush with one held bit
    add_row(8'h00, 1'b1, 2, '{8'h00, 4'd8, 1'b0, 1'b0}, '{8'h60, 4'd2, 1'b1, 1'b1});
    add_row(8'hff, 1'b1, 2, '{8'h7f, 4'd8, 1'b0, 1'b0}, '{8'he0, 4'd2, 1'b1, 1'b1});
    add_row(8'hff, 1'b0, 1, '{8'h7f, 4'd8, 1'b0, 1'b1}, none);
    // climb to seven held bits, then a byte that takes three words
    add_row(8'h00, 1'b0, 0, none, none);
    add_row(8'hff, 1'b0, 0, none, none);
    add_row(8'h00, 1'b0, 0, none, none);
    add_row(8'hff, 1'b1, 0, none, none);
    // flush with seven held bits: no idle bit
    add_row(8'h12, 1'b0, 0, none, none);
    add_row(8'h34, 1'b0, 0, none, none);
    add_row(8'h56, 1'b0, 0, none, none);
    add_row(8'h78, 1'b1, 0, none, none);
    // flush with three held bits
    add_row(8'h9a, 1'b0, 0, none, none);
    add_row(8'hbc, 1'b1, 0, none, none);
    // flush with five held bits
    add_row(8'hde, 1'b0, 0, none, none);
    add_row(8'hf1, 1'b0, 0, none, none);
    add_row(8'h11, 1'b1, 0, none, none);
    // full cycle of counts without a flush at seven
    add_row(8'h01, 1'b0, 0, none, none);
    add_row(8'h80, 1'b0, 0, none, none);
    add_row(8'h55, 1'b0, 0, none, none);
    add_row(8'haa, 1'b0, 0, none, none);
    add_row(8'hc3, 1'b0, 0, none, none);
    add_row(8'h3c, 1'b1, 0, none, none);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (byte_rows[i]) begin
      send_byte(byte_rows[i].data, byte_rows[i].last, source_gap());
      base_len = pending_words.size();
      pack_frame(byte_rows[i].data, byte_rows[i].last);
      if (byte_rows[i].typed > 0) begin
        while (pending_words.size() > base_len) void'(pending_words.pop_back());
        pending_words.push_back(byte_rows[i].t0);
        if (byte_rows[i].typed > 1) pending_words.push_back(byte_rows[i].t1);
      end
    end
    in_chan.valid <= 1'b0;
    wait_drained();

    while (rand_items < 220) begin
      if (!drained_once && rand_items >= 100) begin
        // hold requests until every queued word is out
        in_chan.valid <= 1'b0;
        wait_drained();
        drained_once = 1'b1;
      end
      msg_len = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 12);
      for (int j = 0; j < msg_len && rand_items < 220; j++) begin
        calm = (rand_items >= 140 && rand_items < 180);
        r = $urandom_range(0, 7);
        if (r == 0) d = 8'h00;
        else if (r == 1) d = 8'hff;
        else d = 8'($urandom_range(0, 255));
        l = (j == msg_len - 1) || (rand_items == 219);
        send_byte(d, l, source_gap());
        pack_frame(d, l);
        rand_items++;
      end
    end
    calm = 1'b0;
    in_chan.valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);

    $display("Sent %0d table bytes and %0d random bytes in %0d messages.",
             byte_rows.size(), rand_items, messages);
    $display("Checked %0d line words, %0d of them flush words.", words_seen, flushes);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> uart_frame_word_packer.f
src/ufwp_pkg.sv
src/ufwp_if.sv
src/ufwp_front.sv
src/ufwp_queue.sv
src/ufwp_back.sv
src/uart_frame_word_packer.sv
tb/tb.sv
